// ===== hdl/lgge_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid package
// Shared widths, codes and the control/result types of the row cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lgge_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int KIND_W = 2;
    localparam int CNT_W = 4;
    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;
    // Compare width: holds any row or column index up to the largest grid.
    localparam int CMP_W = 9;

    localparam logic [KIND_W-1:0] KIND_TOGGLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    // B3/S23: a live cell survives with two or three neighbors, a dead one
    // is born with exactly three.
    localparam logic [CNT_W-1:0] LIFE_SURVIVE = 4'd2;
    localparam logic [CNT_W-1:0] LIFE_BIRTH   = 4'd3;

    typedef struct packed {
        logic             toggle;
        logic             advance;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CFG_W-1:0] rows_in_use;
    } t_cell_ctrl;

    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] count;
    } t_cell_res;

endpackage

`default_nettype wire

// ===== hdl/lgge_if.sv =====
// ----------------------------------------------------------------------------
// Life grid channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgge_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [lgge_pkg::KIND_W-1:0] kind;
    logic [lgge_pkg::ROW_W-1:0]  row;
    logic [lgge_pkg::COL_W-1:0]  col;

    modport source (output valid, output kind, output row, output col, input ready);
    modport sink   (input valid, input kind, input row, input col, output ready);
endinterface

interface lgge_res_if;
    logic                       valid;
    logic                       ready;
    logic                       cell_alive;
    logic [lgge_pkg::CNT_W-1:0] neighbour_count;
    logic                       out_of_grid;

    modport source (output valid, output cell_alive, output neighbour_count,
                    output out_of_grid, input ready);
    modport sink   (input valid, input cell_alive, input neighbour_count,
                    input out_of_grid, output ready);
endinterface

interface lgge_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lgge_pkg::CFG_IDX_W-1:0] index;
    logic [lgge_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/life_grid_generation_engine.sv =====
// ----------------------------------------------------------------------------
// Life grid generation engine
// Conway B3/S23 grid held in a chain of row cells, with toggle, step and read.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries kind/row/col. A toggle flips one cell inside the grid in
//   use, an advance updates every cell in use at once (non-wrapping edge),
//   any other kind only reads. Every command gives one transfer on o_res:
//   the addressed cell after the operation and its live neighbor count, or
//   out_of_grid when the address lies outside the grid in use.
//   i_cfg writes rows_in_use (index 0) and cols_in_use (index 1); it is
//   always ready; the user must write it only while the engine is idle,
//   and the block itself does no check of this. The operation is applied
//   to the row cells at the accepting edge; in S_EVAL the addressed window
//   is gathered from three neighbor cells and the result is registered.
//   A new command is taken while a result waits on o_res; if the receiver
//   still stalls when the next result is ready, the engine holds it and
//   accepts nothing more until o_res transfers.
//   Reset clears every cell and sets both registers to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_engine #(
    parameter int MAX_ROWS = lgge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgge_pkg::DEF_MAX_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lgge_cmd_if.sink   i_cmd,
    lgge_res_if.source o_res,
    lgge_cfg_if.sink   i_cfg
);
    import lgge_pkg::*;

    typedef enum logic {S_IDLE, S_EVAL} t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic             r_out_alive;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_oog;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_inside;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;

    logic                cmd_acc;
    logic                in_grid;
    logic [MAX_COLS-1:0] col_mask;
    t_cell_ctrl          ctrl;
    t_cell_res           res_all;

    logic [MAX_COLS-1:0] row_chain [MAX_ROWS+2];
    logic [2:0]          win_chain [MAX_ROWS+2];
    t_cell_res           res_bus   [MAX_ROWS];

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    assign in_grid = ({3'b000, i_cmd.row} < {2'b00, r_rows})
                  && ({3'b000, i_cmd.row} < CMP_W'(MAX_ROWS))
                  && ({3'b000, i_cmd.col} < {2'b00, r_cols})
                  && ({3'b000, i_cmd.col} < CMP_W'(MAX_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROWS_IN_USE: r_rows <= i_cfg.data;
                REG_COLS_IN_USE: r_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col_mask
        assign col_mask[c] = CMP_W'(c) < {2'b00, r_cols};
    end

    // The command address drives the cells at the accepting edge, the held
    // address drives them while the result is gathered.
    always_comb begin
        ctrl.toggle      = cmd_acc && (i_cmd.kind == KIND_TOGGLE) && in_grid;
        ctrl.advance     = cmd_acc && (i_cmd.kind == KIND_ADVANCE);
        ctrl.row         = (r_state == S_IDLE) ? i_cmd.row : r_row;
        ctrl.col         = (r_state == S_IDLE) ? i_cmd.col : r_col;
        ctrl.rows_in_use = r_rows;
    end

    assign row_chain[0]          = '0;
    assign row_chain[MAX_ROWS+1] = '0;
    assign win_chain[0]          = '0;
    assign win_chain[MAX_ROWS+1] = '0;

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_rows
        lgge_row_cell #(
            .MAX_COLS (MAX_COLS),
            .ROW_IDX  (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_col_mask (col_mask),
            .i_up_row   (row_chain[i]),
            .i_dn_row   (row_chain[i+2]),
            .i_up_win   (win_chain[i]),
            .i_dn_win   (win_chain[i+2]),
            .o_row      (row_chain[i+1]),
            .o_win      (win_chain[i+1]),
            .o_res      (res_bus[i])
        );
    end

    // Only the addressed row reports a nonzero result.
    always_comb begin
        res_all = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            res_all = t_cell_res'(res_all | res_bus[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In evaluation the result register is handled by the state arm.
            if (o_res.ready && r_state == S_IDLE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_row    <= i_cmd.row;
                        r_col    <= i_cmd.col;
                        r_inside <= in_grid;
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_alive <= r_inside & res_all.alive;
                        r_out_count <= r_inside ? res_all.count : '0;
                        r_out_oog   <= !r_inside;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.cell_alive      = r_out_alive;
    assign o_res.neighbour_count = r_out_count;
    assign o_res.out_of_grid     = r_out_oog;

    a_accept_evaluates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state == S_EVAL))
        else $error("accepted command did not move to evaluation");

    a_oog_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.out_of_grid) |->
            (!o_res.cell_alive && o_res.neighbour_count == '0))
        else $error("out-of-grid result carries cell data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.neighbour_count <= 4'd8))
        else $error("neighbor count above eight");

    a_eval_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_out_valid && !o_res.ready) |=>
            (r_state == S_EVAL && $stable(r_out_count) && $stable(r_out_alive)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hdl/lgge_row_cell.sv =====
// ----------------------------------------------------------------------------
// Life grid row cell
// Holds one grid row, computes its next generation from the neighbor rows
// and reports the addressed cell and its neighbor count.
// ----------------------------------------------------------------------------
`default_nettype none

module lgge_row_cell #(
    parameter int MAX_COLS = lgge_pkg::DEF_MAX_COLS,
    parameter int ROW_IDX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lgge_pkg::t_cell_ctrl  i_ctrl,
    input  logic [MAX_COLS-1:0]   i_col_mask,
    input  logic [MAX_COLS-1:0]   i_up_row,
    input  logic [MAX_COLS-1:0]   i_dn_row,
    input  logic [2:0]            i_up_win,
    input  logic [2:0]            i_dn_win,
    output logic [MAX_COLS-1:0]   o_row,
    output logic [2:0]            o_win,
    output lgge_pkg::t_cell_res   o_res
);
    import lgge_pkg::*;

    logic [MAX_COLS-1:0] r_bits;
    logic [MAX_COLS-1:0] n_bits;
    logic [MAX_COLS-1:0] live;
    logic [MAX_COLS-1:0] next_gen;
    logic [MAX_COLS-1:0] tog_mask;
    logic [MAX_COLS+1:0] pad_up;
    logic [MAX_COLS+1:0] pad_own;
    logic [MAX_COLS+1:0] pad_dn;
    logic [MAX_COLS+1:0] own_shift;
    logic                row_active;
    logic                row_sel;
    logic [CNT_W-1:0]    win_cnt;

    assign row_active = CMP_W'(ROW_IDX) < {2'b00, i_ctrl.rows_in_use};
    assign row_sel    = CMP_W'(ROW_IDX) == {3'b000, i_ctrl.row};

    // Cells outside the grid in use keep their value but look dead to others.
    assign live    = row_active ? (r_bits & i_col_mask) : '0;
    assign pad_up  = {1'b0, i_up_row, 1'b0};
    assign pad_own = {1'b0, live, 1'b0};
    assign pad_dn  = {1'b0, i_dn_row, 1'b0};

    always_comb begin
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        next_gen = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            cnt = CNT_W'(pad_up[c]) + CNT_W'(pad_up[c+1]) + CNT_W'(pad_up[c+2])
                + CNT_W'(pad_own[c]) + CNT_W'(pad_own[c+2])
                + CNT_W'(pad_dn[c]) + CNT_W'(pad_dn[c+1]) + CNT_W'(pad_dn[c+2]);
            next_gen[c] = live[c] ? (cnt == LIFE_SURVIVE || cnt == LIFE_BIRTH)
                                  : (cnt == LIFE_BIRTH);
        end
    end

    assign tog_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << i_ctrl.col;

    always_comb begin
        n_bits = r_bits;
        if (i_ctrl.advance && row_active) begin
            n_bits = (next_gen & i_col_mask) | (r_bits & ~i_col_mask);
        end else if (i_ctrl.toggle && row_sel) begin
            n_bits = r_bits ^ tog_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            r_bits <= n_bits;
        end
    end

    // Three-cell window around the addressed column, for the neighbor rows.
    assign own_shift = pad_own >> i_ctrl.col;
    assign o_win     = own_shift[2:0];
    assign o_row     = live;

    assign win_cnt = CNT_W'(i_up_win[0]) + CNT_W'(i_up_win[1]) + CNT_W'(i_up_win[2])
                   + CNT_W'(o_win[0]) + CNT_W'(o_win[2])
                   + CNT_W'(i_dn_win[0]) + CNT_W'(i_dn_win[1]) + CNT_W'(i_dn_win[2]);

    assign o_res.alive = row_sel & o_win[1];
    assign o_res.count = row_sel ? win_cnt : '0;

endmodule

`default_nettype wire
